[sv/relay_display_latch_keypad_assert.svh]
// ----------------------------------------------------------------------------
// Relay display latch keypad assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef RELAY_DISPLAY_LATCH_KEYPAD_ASSERT_SVH
`define RELAY_DISPLAY_LATCH_KEYPAD_ASSERT_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset
`define RDLK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included
`define RDLK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDLK_ASSERT(lbl, clk, rst_n, prop, msg)
`define RDLK_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/rdlk_pkg.sv]
// ----------------------------------------------------------------------------
// Relay display latch keypad package
// Field widths, operation and register codes, bank map and relay decode.
// ----------------------------------------------------------------------------
package rdlk_pkg;

  localparam int DIGIT_COUNT = 21;
  localparam int WIRED_BANKS = 13;
  localparam int HOLD_W      = 24;
  localparam int WORD_W      = 15;
  localparam int LAMP_W      = 15;
  localparam int CFG_W       = 24;

  localparam int POS_PROG1 = 15;
  localparam int REG_DIGITS = 15;
  localparam int PVN_DIGITS = 6;

  localparam logic [3:0] BLANK       = 4'd15;
  localparam logic [3:0] STATUS_BANK = 4'd12;
  localparam logic [4:0] POS_NONE    = 5'd31;
  localparam logic [1:0] SREG_NONE   = 2'd3;

  typedef logic [3:0] digit_t;

  typedef enum logic [2:0] {
    OP_RELAY   = 3'd0,
    OP_LAMP    = 3'd1,
    OP_TICK    = 3'd2,
    OP_MAIN    = 3'd3,
    OP_NAV     = 3'd4,
    OP_RELEASE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CFG_DEFAULT_HOLD = 2'd0,
    CFG_KEY_REL_MASK = 2'd1,
    CFG_OPR_ERR_MASK = 2'd2,
    CFG_FLASH_EN_MASK = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0] left;
    logic [4:0] right;
    logic [1:0] sreg;
    logic       plus;
  } bank_map_t;

  // Digit positions: 0..14 R1D1..R3D5, 15..16 PROG, 17..18 VERB, 19..20 NOUN
  function automatic bank_map_t bank_map(input logic [3:0] bank);
    bank_map_t m;
    m = '{left: POS_NONE, right: POS_NONE, sreg: SREG_NONE, plus: 1'b0};
    case (bank)
      4'd1:    m = '{left: 5'd13, right: 5'd14, sreg: 2'd2, plus: 1'b0};
      4'd2:    m = '{left: 5'd11, right: 5'd12, sreg: 2'd2, plus: 1'b1};
      4'd3:    m = '{left: 5'd9,  right: 5'd10, sreg: SREG_NONE, plus: 1'b0};
      4'd4:    m = '{left: 5'd7,  right: 5'd8,  sreg: 2'd1, plus: 1'b0};
      4'd5:    m = '{left: 5'd5,  right: 5'd6,  sreg: 2'd1, plus: 1'b1};
      4'd6:    m = '{left: 5'd3,  right: 5'd4,  sreg: 2'd0, plus: 1'b0};
      4'd7:    m = '{left: 5'd1,  right: 5'd2,  sreg: 2'd0, plus: 1'b1};
      4'd8:    m = '{left: POS_NONE, right: 5'd0, sreg: SREG_NONE, plus: 1'b0};
      4'd9:    m = '{left: 5'd19, right: 5'd20, sreg: SREG_NONE, plus: 1'b0};
      4'd10:   m = '{left: 5'd17, right: 5'd18, sreg: SREG_NONE, plus: 1'b0};
      4'd11:   m = '{left: 5'd15, right: 5'd16, sreg: SREG_NONE, plus: 1'b0};
      default: m = '{left: POS_NONE, right: POS_NONE, sreg: SREG_NONE, plus: 1'b0};
    endcase
    return m;
  endfunction

  // Relay code to display digit; anything unlisted shows blank
  function automatic digit_t code_to_digit(input logic [4:0] code);
    digit_t d;
    case (code)
      5'o25:   d = 4'd0;
      5'o03:   d = 4'd1;
      5'o31:   d = 4'd2;
      5'o33:   d = 4'd3;
      5'o17:   d = 4'd4;
      5'o36:   d = 4'd5;
      5'o34:   d = 4'd6;
      5'o23:   d = 4'd7;
      5'o35:   d = 4'd8;
      5'o37:   d = 4'd9;
      default: d = BLANK;
    endcase
    return d;
  endfunction

endpackage

[sv/rdlk_if.sv]
// ----------------------------------------------------------------------------
// Relay display latch keypad channels
// Request channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rdlk_in_if;
  import rdlk_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [WORD_W-1:0] word;
  logic [HOLD_W-1:0] hold_ticks;
  logic              flash_in;

  modport source (output valid, op, word, hold_ticks, flash_in, input ready);
  modport sink   (input valid, op, word, hold_ticks, flash_in, output ready);
endinterface

interface rdlk_out_if;
  import rdlk_pkg::*;

  logic              valid;
  logic              ready;
  logic [59:0]       register_digits;
  logic [23:0]       prog_verb_noun_digits;
  logic [5:0]        sign_bits;
  logic [10:0]       status_word;
  logic [LAMP_W-1:0] lamp_word;
  logic [2:0]        lamp_visible;
  logic [4:0]        key_main_code;
  logic [6:0]        key_nav_bits;
  logic [1:0]        keyrupt_pulse;

  modport source (output valid, register_digits, prog_verb_noun_digits, sign_bits,
                  status_word, lamp_word, lamp_visible, key_main_code, key_nav_bits,
                  keyrupt_pulse, input ready);
  modport sink   (input valid, register_digits, prog_verb_noun_digits, sign_bits,
                  status_word, lamp_word, lamp_visible, key_main_code, key_nav_bits,
                  keyrupt_pulse, output ready);
endinterface

[sv/relay_display_latch_keypad.sv]
// ----------------------------------------------------------------------------
// Relay display latch keypad
// Display digit, sign, status and lamp latches plus keypad hold timers.
// ----------------------------------------------------------------------------
// A request is captured in the input register; processing it then updates
// the latches and loads the full display snapshot into the result register.
// Throughput is one request every cycle as long as the result register is
// drained; a stalled result register holds the input register, which then
// holds in_ch.ready low.
// Every request produces exactly one result showing the state after it.
`include "relay_display_latch_keypad_assert.svh"

module relay_display_latch_keypad (
  input  logic                      clk,
  input  logic                      rst_n,
  rdlk_in_if.sink                   in_ch,
  rdlk_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [rdlk_pkg::CFG_W-1:0] cfg_data
);
  import rdlk_pkg::*;

  // Configuration registers
  logic [HOLD_W-1:0] cfg_hold_r;
  logic [LAMP_W-1:0] cfg_key_rel_r;
  logic [LAMP_W-1:0] cfg_opr_err_r;
  logic [LAMP_W-1:0] cfg_flash_en_r;

  // Input register
  logic              in_valid_r;
  logic [2:0]        in_op_r;
  logic [WORD_W-1:0] in_word_r;
  logic [HOLD_W-1:0] in_hold_r;
  logic              in_flash_r;

  // Display and keypad state
  digit_t            digit_r   [DIGIT_COUNT];
  digit_t            digit_nxt [DIGIT_COUNT];
  logic [2:0]        plus_r, plus_nxt;
  logic [2:0]        minus_r, minus_nxt;
  logic [10:0]       status_r, status_nxt;
  logic [LAMP_W-1:0] lamp_r, lamp_nxt;
  logic              flash_r, flash_nxt;
  logic [4:0]        main_key_r, main_key_nxt;
  logic [6:0]        nav_key_r, nav_key_nxt;
  logic [HOLD_W-1:0] main_hold_r, main_hold_nxt;
  logic [HOLD_W-1:0] nav_hold_r, nav_hold_nxt;
  logic [1:0]        pulse_nxt;

  // Result register
  logic              out_valid_r;
  logic [59:0]       regd_r, regd_nxt;
  logic [23:0]       pvn_r, pvn_nxt;
  logic [5:0]        signs_r, signs_nxt;
  logic [2:0]        vis_r, vis_nxt;
  logic [1:0]        pulse_r;

  logic              advance;
  logic              process;
  logic [3:0]        bank;
  logic [10:0]       relays;
  bank_map_t         bmap;
  logic [HOLD_W-1:0] hold_pick;

  // Advance when the result register is free or being drained
  assign advance     = !out_valid_r || out_ch.ready;
  assign process     = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_hold_r     <= HOLD_W'(102400);
      cfg_key_rel_r  <= LAMP_W'(16);
      cfg_opr_err_r  <= LAMP_W'(64);
      cfg_flash_en_r <= LAMP_W'(32);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEFAULT_HOLD:  cfg_hold_r     <= cfg_data[HOLD_W-1:0];
        CFG_KEY_REL_MASK:  cfg_key_rel_r  <= cfg_data[LAMP_W-1:0];
        CFG_OPR_ERR_MASK:  cfg_opr_err_r  <= cfg_data[LAMP_W-1:0];
        CFG_FLASH_EN_MASK: cfg_flash_en_r <= cfg_data[LAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_op_r    <= in_ch.op;
      in_word_r  <= in_ch.word;
      in_hold_r  <= in_ch.hold_ticks;
      in_flash_r <= in_ch.flash_in;
    end
  end

  // Decode relay word and hold choice
  assign bank      = in_word_r[14:11];
  assign relays    = in_word_r[10:0];
  assign bmap      = bank_map(bank);
  assign hold_pick = (in_hold_r != '0) ? in_hold_r : cfg_hold_r;

  // Next state for one request
  always_comb begin
    digit_nxt     = digit_r;
    plus_nxt      = plus_r;
    minus_nxt     = minus_r;
    status_nxt    = status_r;
    lamp_nxt      = lamp_r;
    flash_nxt     = flash_r;
    main_key_nxt  = main_key_r;
    nav_key_nxt   = nav_key_r;
    main_hold_nxt = main_hold_r;
    nav_hold_nxt  = nav_hold_r;
    pulse_nxt     = 2'b00;
    case (op_t'(in_op_r))
      OP_RELAY: begin
        if (bank == STATUS_BANK) begin
          status_nxt = relays;
        end else if (bank < 4'(WIRED_BANKS)) begin
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (bmap.left == 5'(i)) digit_nxt[i] = code_to_digit(relays[9:5]);
            if (bmap.right == 5'(i)) digit_nxt[i] = code_to_digit(relays[4:0]);
          end
          if (bmap.sreg != SREG_NONE) begin
            if (bmap.plus) plus_nxt[bmap.sreg] = relays[10];
            else           minus_nxt[bmap.sreg] = relays[10];
          end
        end
      end
      OP_LAMP: begin
        lamp_nxt = in_word_r;
      end
      OP_TICK: begin
        flash_nxt = in_flash_r;
        if (main_hold_r != '0) begin
          main_hold_nxt = main_hold_r - HOLD_W'(1);
          if (main_hold_r == HOLD_W'(1)) main_key_nxt = '0;
        end
        if (nav_hold_r != '0) begin
          nav_hold_nxt = nav_hold_r - HOLD_W'(1);
          if (nav_hold_r == HOLD_W'(1)) nav_key_nxt = '0;
        end
      end
      OP_MAIN: begin
        main_key_nxt  = in_word_r[4:0];
        main_hold_nxt = hold_pick;
        pulse_nxt     = 2'b01;
      end
      OP_NAV: begin
        nav_key_nxt  = in_word_r[6:0];
        nav_hold_nxt = hold_pick;
        pulse_nxt    = 2'b10;
      end
      OP_RELEASE: begin
        main_key_nxt  = '0;
        nav_key_nxt   = '0;
        main_hold_nxt = '0;
        nav_hold_nxt  = '0;
      end
      default: ;
    endcase
  end

  // Pack the display snapshot from the next state
  always_comb begin
    regd_nxt = '0;
    pvn_nxt  = '0;
    for (int i = 0; i < REG_DIGITS; i++) begin
      regd_nxt[59-4*i -: 4] = digit_nxt[i];
    end
    for (int i = 0; i < PVN_DIGITS; i++) begin
      pvn_nxt[23-4*i -: 4] = digit_nxt[POS_PROG1+i];
    end
    for (int i = 0; i < 3; i++) begin
      signs_nxt[2*i]   = plus_nxt[i];
      signs_nxt[2*i+1] = minus_nxt[i];
    end
    vis_nxt[0] = ((lamp_nxt & cfg_key_rel_r) != '0) && !flash_nxt;
    vis_nxt[1] = ((lamp_nxt & cfg_opr_err_r) != '0) && !flash_nxt;
    vis_nxt[2] = ((lamp_nxt & cfg_flash_en_r) == '0) || flash_nxt;
  end

  // Update latches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) digit_r[i] <= BLANK;
      plus_r      <= '0;
      minus_r     <= '0;
      status_r    <= '0;
      lamp_r      <= '0;
      flash_r     <= 1'b0;
      main_key_r  <= '0;
      nav_key_r   <= '0;
      main_hold_r <= '0;
      nav_hold_r  <= '0;
    end else if (process) begin
      digit_r     <= digit_nxt;
      plus_r      <= plus_nxt;
      minus_r     <= minus_nxt;
      status_r    <= status_nxt;
      lamp_r      <= lamp_nxt;
      flash_r     <= flash_nxt;
      main_key_r  <= main_key_nxt;
      nav_key_r   <= nav_key_nxt;
      main_hold_r <= main_hold_nxt;
      nav_hold_r  <= nav_hold_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      regd_r  <= regd_nxt;
      pvn_r   <= pvn_nxt;
      signs_r <= signs_nxt;
      vis_r   <= vis_nxt;
      pulse_r <= pulse_nxt;
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.register_digits       = regd_r;
  assign out_ch.prog_verb_noun_digits = pvn_r;
  assign out_ch.sign_bits             = signs_r;
  assign out_ch.status_word           = status_r;
  assign out_ch.lamp_word             = lamp_r;
  assign out_ch.lamp_visible          = vis_r;
  assign out_ch.key_main_code         = main_key_r;
  assign out_ch.key_nav_bits          = nav_key_r;
  assign out_ch.keyrupt_pulse         = pulse_r;

  // Internal checks
  `RDLK_ASSERT(a_stall_holds_request, clk, rst_n,
    in_valid_r && !advance |=> in_valid_r && $stable(in_op_r) && $stable(in_word_r),
    "stalled request changed")
  `RDLK_ASSERT(a_processed_gives_result, clk, rst_n,
    process |=> out_valid_r, "processed request gave no result")
  `RDLK_ASSERT(a_last_tick_clears_main, clk, rst_n,
    process && (in_op_r == OP_TICK) && (main_hold_r == HOLD_W'(1)) |=> main_key_r == '0,
    "main key survived the end of its hold")
  `RDLK_ASSERT(a_lamp_vis_consistent, clk, rst_n,
    out_valid_r && vis_r[0] |-> vis_r[2] == ((lamp_r & cfg_flash_en_r) == '0),
    "verb/noun visibility disagrees with flash level")
  `RDLK_ASSERT_ALWAYS(a_reset_empties_pipe, clk,
    $past(!rst_n) |-> !in_valid_r && !out_valid_r, "pipeline not empty after reset")

endmodule
